// ----- hdl/osl_pkg.sv -----
`default_nettype none
package osl_pkg;
    localparam int NAME_MAX_DEF = 32;
    localparam int KEYWORD_COUNT_DEF = 34;
    localparam int COMMENT_DEPTH_BITS_DEF = 16;

    localparam logic [5:0] K_NAME  = 6'd0;
    localparam logic [5:0] K_NUM   = 6'd1;
    localparam logic [5:0] K_NONE  = 6'd2;
    localparam logic [5:0] K_SEMI  = 6'd17;
    localparam logic [5:0] K_ASS   = 6'd18;
    localparam logic [5:0] K_COLON = 6'd19;
    localparam logic [5:0] K_DOT   = 6'd20;
    localparam logic [5:0] K_COMMA = 6'd21;
    localparam logic [5:0] K_EQ    = 6'd22;
    localparam logic [5:0] K_NE    = 6'd23;
    localparam logic [5:0] K_LE    = 6'd24;
    localparam logic [5:0] K_LT    = 6'd25;
    localparam logic [5:0] K_GE    = 6'd26;
    localparam logic [5:0] K_GT    = 6'd27;
    localparam logic [5:0] K_LPAR  = 6'd28;
    localparam logic [5:0] K_RPAR  = 6'd29;
    localparam logic [5:0] K_PLUS  = 6'd30;
    localparam logic [5:0] K_MINUS = 6'd31;
    localparam logic [5:0] K_MULT  = 6'd32;
    localparam logic [5:0] K_END   = 6'd33;
    localparam logic [5:0] K_ERR   = 6'd34;

    localparam logic [1:0] E_NAME    = 2'd0;
    localparam logic [1:0] E_NUMBER  = 2'd1;
    localparam logic [1:0] E_ILLEGAL = 2'd2;
    localparam logic [1:0] E_COMMENT = 2'd3;

    // queue entry between front and back
    localparam logic [2:0] OP_TOKEN = 3'd0; // single token, kind/num/err given
    localparam logic [2:0] OP_FLUSH = 3'd1; // identifier flush
    localparam logic [2:0] OP_NAME  = 3'd2; // identifier character write

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  kind;
        logic [30:0] num;
        logic [1:0]  err;
        logic [7:0]  ch;
        logic [5:0]  idx;
        logic        last;
    } t_cmd;

    localparam int KW_LEN = 9;

    typedef struct packed {
        logic [KW_LEN*8-1:0] word;
        logic [3:0]          len;
        logic [5:0]          kind;
    } t_kw;

    function automatic t_kw kw_entry(input logic [5:0] i);
        t_kw k;
        k = '{word: '0, len: 4'd0, kind: 6'd2};
        case (i)
            6'd0:  k = '{word: {"ARRAY", 32'h0}, len: 4'd5, kind: 6'd2};
            6'd1:  k = '{word: {"BY", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd2:  k = '{word: {"BEGIN", 32'h0}, len: 4'd5, kind: 6'd3};
            6'd3:  k = '{word: {"CASE", 40'h0}, len: 4'd4, kind: 6'd2};
            6'd4:  k = '{word: {"CONST", 32'h0}, len: 4'd5, kind: 6'd4};
            6'd5:  k = '{word: {"DIV", 48'h0}, len: 4'd3, kind: 6'd5};
            6'd6:  k = '{word: {"DO", 56'h0}, len: 4'd2, kind: 6'd6};
            6'd7:  k = '{word: {"ELSE", 40'h0}, len: 4'd4, kind: 6'd7};
            6'd8:  k = '{word: {"ELSIF", 32'h0}, len: 4'd5, kind: 6'd8};
            6'd9:  k = '{word: {"END", 48'h0}, len: 4'd3, kind: 6'd9};
            6'd10: k = '{word: {"EXIT", 40'h0}, len: 4'd4, kind: 6'd2};
            6'd11: k = '{word: {"FOR", 48'h0}, len: 4'd3, kind: 6'd2};
            6'd12: k = '{word: {"IF", 56'h0}, len: 4'd2, kind: 6'd10};
            6'd13: k = '{word: {"IMPORT", 24'h0}, len: 4'd6, kind: 6'd11};
            6'd14: k = '{word: {"IN", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd15: k = '{word: {"IS", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd16: k = '{word: {"LOOP", 40'h0}, len: 4'd4, kind: 6'd2};
            6'd17: k = '{word: {"MOD", 48'h0}, len: 4'd3, kind: 6'd12};
            6'd18: k = '{word: {"MODULE", 24'h0}, len: 4'd6, kind: 6'd13};
            6'd19: k = '{word: {"NIL", 48'h0}, len: 4'd3, kind: 6'd2};
            6'd20: k = '{word: {"OF", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd21: k = '{word: {"OR", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd22: k = '{word: {"POINTER", 16'h0}, len: 4'd7, kind: 6'd2};
            6'd23: k = '{word: "PROCEDURE", len: 4'd9, kind: 6'd2};
            6'd24: k = '{word: {"RECORD", 24'h0}, len: 4'd6, kind: 6'd2};
            6'd25: k = '{word: {"REPEAT", 24'h0}, len: 4'd6, kind: 6'd2};
            6'd26: k = '{word: {"RETURN", 24'h0}, len: 4'd6, kind: 6'd2};
            6'd27: k = '{word: {"THEN", 40'h0}, len: 4'd4, kind: 6'd14};
            6'd28: k = '{word: {"TO", 56'h0}, len: 4'd2, kind: 6'd2};
            6'd29: k = '{word: {"TYPE", 40'h0}, len: 4'd4, kind: 6'd2};
            6'd30: k = '{word: {"UNTIL", 32'h0}, len: 4'd5, kind: 6'd2};
            6'd31: k = '{word: {"VAR", 48'h0}, len: 4'd3, kind: 6'd15};
            6'd32: k = '{word: {"WHILE", 32'h0}, len: 4'd5, kind: 6'd16};
            6'd33: k = '{word: {"WITH", 40'h0}, len: 4'd4, kind: 6'd2};
            default: k = '{word: '0, len: 4'd0, kind: 6'd2};
        endcase
        return k;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/oberon_subset_lexer.sv -----
`default_nettype none
// A single token passes through the front's command register and the back's
// output register; a keyword or name first walks the keyword table.
// Input is taken one character at a time; it stalls while that character's
// commands wait, and while an identifier is matched and its name characters are sent.
// Reset: synchronous, active low; clears scan state and the valid flags of the
// command stage and the output register. The name store is not cleared.
module oberon_subset_lexer #(
    parameter int NAME_MAX = osl_pkg::NAME_MAX_DEF,
    parameter int KEYWORD_COUNT = osl_pkg::KEYWORD_COUNT_DEF,
    parameter int COMMENT_DEPTH_BITS = osl_pkg::COMMENT_DEPTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_end_of_text,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [5:0]       o_kind,
    output logic [7:0]       o_name_char,
    output logic             o_name_end,
    output logic [30:0]      o_number_value,
    output logic [1:0]       o_error_code,
    output logic             o_last
);
    import osl_pkg::*;

    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    osl_front #(.NAME_MAX(NAME_MAX), .COMMENT_DEPTH_BITS(COMMENT_DEPTH_BITS)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_ch, .i_end_of_text,
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready)
    );

    osl_back #(.NAME_MAX(NAME_MAX), .KEYWORD_COUNT(KEYWORD_COUNT)) u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .o_empty, .i_pop, .o_kind, .o_name_char, .o_name_end, .o_number_value,
        .o_error_code, .o_last
    );
endmodule
`default_nettype wire

// ----- hdl/osl_front.sv -----
`default_nettype none
module osl_front #(
    parameter int NAME_MAX = osl_pkg::NAME_MAX_DEF,
    parameter int COMMENT_DEPTH_BITS = osl_pkg::COMMENT_DEPTH_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [7:0]   i_ch,
    input  wire logic         i_end_of_text,
    output osl_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  wire logic         i_cmd_ready
);
    import osl_pkg::*;

    localparam logic [3:0] M_IDLE = 4'd0, M_IDENT = 4'd1, M_NUMBER = 4'd2,
        M_COLON = 4'd3, M_LESS = 4'd4, M_GREATER = 4'd5, M_LPAREN = 4'd6,
        M_COMMENT = 4'd7, M_HALTED = 4'd8;
    localparam logic [30:0] NUM_MAX = 31'h7FFFFFFF;
    localparam logic [COMMENT_DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // Each character becomes up to two commands; the second is held here.
    logic [3:0]  r_mode, n_mode;
    logic [5:0]  r_len, n_len;
    logic [30:0] r_acc, n_acc;
    logic [COMMENT_DEPTH_BITS-1:0] r_depth, n_depth;
    logic        r_star, n_star, r_open, n_open;
    logic        r_busy, n_busy;
    t_cmd        r_c0, n_c0, r_c1, n_c1;
    logic        r_v0, n_v0, r_v1, n_v1;

    logic        acc_in;
    logic        letter, digit, alnum;
    logic [3:0]  dv;
    logic [34:0] mul10;

    assign o_full = r_busy;
    assign acc_in = i_push && !r_busy;
    assign letter = (i_ch >= 8'd65 && i_ch <= 8'd90) || (i_ch >= 8'd97 && i_ch <= 8'd122);
    assign digit = i_ch >= 8'd48 && i_ch <= 8'd57;
    assign alnum = letter || digit;
    assign dv = i_ch[3:0];
    assign mul10 = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {31'd0, dv};
    assign o_cmd = r_c0;
    assign o_cmd_valid = r_v0;

    function automatic t_cmd tok(input logic [5:0] k);
        t_cmd c;
        c = '0;
        c.op = OP_TOKEN;
        c.kind = k;
        return c;
    endfunction

    always_comb begin
        t_cmd a, b;
        logic va, vb, fresh;
        n_mode = r_mode; n_len = r_len; n_acc = r_acc; n_depth = r_depth;
        n_star = r_star; n_open = r_open;
        n_c0 = r_c0; n_c1 = r_c1; n_v0 = r_v0; n_v1 = r_v1; n_busy = r_busy;
        a = '0; b = '0; va = 1'b0; vb = 1'b0; fresh = 1'b0;
        if (r_v0 && i_cmd_ready) begin
            n_c0 = r_c1; n_v0 = r_v1; n_v1 = 1'b0;
            if (!r_v1) n_busy = 1'b0;
        end
        if (acc_in && r_mode != M_HALTED) begin
            if (i_end_of_text) begin
                va = 1'b1;
                case (r_mode)
                    M_IDENT: begin a = '0; a.op = OP_FLUSH; a.idx = r_len; end
                    M_NUMBER: begin a = tok(K_NUM); a.num = r_acc; end
                    M_COLON: a = tok(K_COLON);
                    M_LESS: a = tok(K_LT);
                    M_GREATER: a = tok(K_GT);
                    M_LPAREN: a = tok(K_LPAR);
                    default: va = 1'b0;
                endcase
                if (r_mode == M_COMMENT) begin
                    b = tok(K_ERR); b.err = E_COMMENT; n_mode = M_HALTED;
                end else begin
                    b = tok(K_END); n_mode = M_IDLE;
                end
                vb = 1'b1;
            end else begin
                case (r_mode)
                    M_IDENT: begin
                        if (alnum) begin
                            if (r_len < 6'(NAME_MAX)) begin
                                a = '0; a.op = OP_NAME; a.ch = i_ch; a.idx = r_len;
                                va = 1'b1; n_len = r_len + 6'd1;
                            end else begin
                                a = tok(K_ERR); a.err = E_NAME; va = 1'b1;
                                n_mode = M_HALTED;
                            end
                        end else begin
                            a = '0; a.op = OP_FLUSH; a.idx = r_len; va = 1'b1; fresh = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (digit) begin
                            if (mul10 <= 35'(NUM_MAX)) n_acc = mul10[30:0];
                            else begin
                                a = tok(K_ERR); a.err = E_NUMBER; va = 1'b1;
                                n_mode = M_HALTED;
                            end
                        end else begin
                            a = tok(K_NUM); a.num = r_acc; va = 1'b1; fresh = 1'b1;
                        end
                    end
                    M_COLON, M_LESS, M_GREATER: begin
                        va = 1'b1;
                        if (i_ch == 8'd61) begin
                            a = tok(r_mode == M_COLON ? K_ASS :
                                    r_mode == M_LESS ? K_LE : K_GE);
                            n_mode = M_IDLE;
                        end else begin
                            a = tok(r_mode == M_COLON ? K_COLON :
                                    r_mode == M_LESS ? K_LT : K_GT);
                            fresh = 1'b1;
                        end
                    end
                    M_LPAREN: begin
                        if (i_ch == 8'd42) begin
                            n_depth = COMMENT_DEPTH_BITS'(1); n_star = 1'b0; n_open = 1'b0;
                            n_mode = M_COMMENT;
                        end else begin
                            a = tok(K_LPAR); va = 1'b1; fresh = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (r_star && i_ch == 8'd41) begin
                            n_star = 1'b0;
                            if (r_depth <= COMMENT_DEPTH_BITS'(1)) begin
                                n_depth = '0; n_mode = M_IDLE;
                            end else n_depth = r_depth - 1'b1;
                        end else if (r_open && i_ch == 8'd42) begin
                            n_open = 1'b0; n_star = 1'b0;
                            if (r_depth != DEPTH_MAX) n_depth = r_depth + 1'b1;
                        end else begin
                            n_star = i_ch == 8'd42;
                            n_open = i_ch == 8'd40;
                        end
                    end
                    default: fresh = 1'b1;
                endcase
                if (fresh) begin
                    n_mode = M_IDLE;
                    if (i_ch == 8'd32 || i_ch == 8'd9 || i_ch == 8'd10) begin
                    end else if (letter) begin
                        b = '0; b.op = OP_NAME; b.ch = i_ch; b.idx = 6'd0; vb = 1'b1;
                        n_len = 6'd1; n_mode = M_IDENT;
                    end else if (digit) begin
                        n_acc = {27'd0, dv}; n_mode = M_NUMBER;
                    end else begin
                        vb = 1'b1;
                        case (i_ch)
                            8'd58: begin vb = 1'b0; n_mode = M_COLON; end
                            8'd60: begin vb = 1'b0; n_mode = M_LESS; end
                            8'd62: begin vb = 1'b0; n_mode = M_GREATER; end
                            8'd40: begin vb = 1'b0; n_mode = M_LPAREN; end
                            8'd59: b = tok(K_SEMI);
                            8'd46: b = tok(K_DOT);
                            8'd44: b = tok(K_COMMA);
                            8'd61: b = tok(K_EQ);
                            8'd35: b = tok(K_NE);
                            8'd41: b = tok(K_RPAR);
                            8'd43: b = tok(K_PLUS);
                            8'd45: b = tok(K_MINUS);
                            8'd42: b = tok(K_MULT);
                            default: begin
                                b = tok(K_ERR); b.err = E_ILLEGAL; n_mode = M_HALTED;
                            end
                        endcase
                    end
                end
            end
            // last marks the character's final command; a name write in b never takes it
            if (vb && b.op != OP_NAME) begin
                b.last = 1'b1;
            end else if (va) begin
                a.last = 1'b1;
            end
            if (va && vb) begin
                n_c0 = a; n_v0 = 1'b1; n_c1 = b; n_v1 = 1'b1; n_busy = 1'b1;
            end else if (va || vb) begin
                n_c0 = va ? a : b; n_v0 = 1'b1; n_v1 = 1'b0; n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_len <= '0; r_acc <= '0; r_depth <= '0;
            r_star <= 1'b0; r_open <= 1'b0; r_busy <= 1'b0; r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            r_mode <= n_mode; r_len <= n_len; r_acc <= n_acc; r_depth <= n_depth;
            r_star <= n_star; r_open <= n_open; r_busy <= n_busy;
            r_v0 <= n_v0; r_v1 <= n_v1;
        end
        r_c0 <= n_c0;
        r_c1 <= n_c1;
    end
endmodule
`default_nettype wire

// ----- hdl/osl_back.sv -----
`default_nettype none
module osl_back #(
    parameter int NAME_MAX = osl_pkg::NAME_MAX_DEF,
    parameter int KEYWORD_COUNT = osl_pkg::KEYWORD_COUNT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire osl_pkg::t_cmd i_cmd,
    input  wire logic         i_cmd_valid,
    output logic              o_cmd_ready,
    output logic              o_empty,
    input  wire logic         i_pop,
    output logic [5:0]        o_kind,
    output logic [7:0]        o_name_char,
    output logic              o_name_end,
    output logic [30:0]       o_number_value,
    output logic [1:0]        o_error_code,
    output logic              o_last
);
    import osl_pkg::*;

    localparam int AW = $clog2(NAME_MAX);
    localparam logic [1:0] S_IDLE = 2'd0, S_KW = 2'd1, S_EMIT = 2'd2;

    logic [7:0]  mem [NAME_MAX];
    logic [7:0]  r_kwbuf [KW_LEN];
    logic [1:0]  r_st, n_st;
    logic [5:0]  r_len, n_len, r_i, n_i;
    logic        r_last, n_last;
    logic        r_ov, n_ov;
    logic [5:0]  r_kind, n_kind;
    logic [7:0]  r_nc, n_nc;
    logic        r_ne, n_ne;
    logic [30:0] r_num, n_num;
    logic [1:0]  r_err, n_err;
    logic        r_ol, n_ol;
    logic [7:0]  r_rd;
    logic        r_rdv, n_rdv;
    logic        out_free;
    logic        kw_hit;
    t_kw         kw;
    logic [AW-1:0] rd_addr;

    assign out_free = !r_ov || i_pop;
    assign o_empty = !r_ov;
    assign o_kind = r_kind;
    assign o_name_char = r_nc;
    assign o_name_end = r_ne;
    assign o_number_value = r_num;
    assign o_error_code = r_err;
    assign o_last = r_ol;
    assign o_cmd_ready = r_st == S_IDLE && (i_cmd.op == OP_NAME || out_free);
    assign kw = kw_entry(r_i);
    assign rd_addr = AW'(n_i);

    always_comb begin
        kw_hit = {2'b00, kw.len} == r_len;
        for (int j = 0; j < KW_LEN; j++)
            if (j < int'(kw.len) && kw.word[(KW_LEN-1-j)*8 +: 8] != r_kwbuf[j]) kw_hit = 1'b0;
    end

    always_comb begin
        n_st = r_st; n_len = r_len; n_i = r_i; n_last = r_last; n_ov = r_ov;
        n_kind = r_kind; n_nc = r_nc; n_ne = r_ne; n_num = r_num; n_err = r_err; n_ol = r_ol;
        n_rdv = 1'b0;
        if (r_ov && i_pop) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    if (i_cmd.op == OP_TOKEN) begin
                        n_ov = 1'b1; n_kind = i_cmd.kind; n_nc = '0; n_ne = 1'b0;
                        n_num = i_cmd.num; n_err = i_cmd.err; n_ol = i_cmd.last;
                    end else if (i_cmd.op == OP_FLUSH) begin
                        n_len = i_cmd.idx; n_last = i_cmd.last; n_i = '0; n_st = S_KW;
                    end
                end
            end
            S_KW: begin
                if (kw_hit && out_free) begin
                    n_ov = 1'b1; n_kind = kw.kind; n_nc = '0; n_ne = 1'b0; n_num = '0;
                    n_err = '0; n_ol = r_last; n_st = S_IDLE;
                end else if (!kw_hit) begin
                    if (r_i == 6'(KEYWORD_COUNT - 1)) begin
                        n_i = '0; n_st = S_EMIT; n_rdv = 1'b1;
                    end else n_i = r_i + 6'd1;
                end
            end
            S_EMIT: begin
                n_rdv = 1'b1;
                if (r_rdv && out_free) begin
                    n_ov = 1'b1; n_kind = K_NAME; n_nc = r_rd; n_num = '0; n_err = '0;
                    n_ne = r_i + 6'd1 == r_len;
                    n_ol = n_ne && r_last;
                    if (n_ne) begin
                        n_st = S_IDLE; n_rdv = 1'b0;
                    end else begin
                        n_i = r_i + 6'd1; n_rdv = 1'b0;
                    end
                end else if (!r_rdv) n_rdv = 1'b1;
                else n_rdv = 1'b1;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_cmd_valid && i_cmd.op == OP_NAME) begin
            mem[AW'(i_cmd.idx)] <= i_cmd.ch;
            if (i_cmd.idx < 6'(KW_LEN)) r_kwbuf[4'(i_cmd.idx)] <= i_cmd.ch;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_rdv <= 1'b0; r_i <= '0; r_len <= '0;
            r_last <= 1'b0;
        end else begin
            r_st <= n_st; r_ov <= n_ov; r_rdv <= n_rdv; r_i <= n_i; r_len <= n_len;
            r_last <= n_last;
        end
        r_kind <= n_kind; r_nc <= n_nc; r_ne <= n_ne; r_num <= n_num;
        r_err <= n_err; r_ol <= n_ol;
    end
endmodule
`default_nettype wire
